// ===== sv/cle_pkg.sv =====
package cle_pkg;

  // default line store depth
  localparam int unsigned LineDepthDef = 31;

  // key codes
  localparam logic [7:0] KeyBs    = 8'd8;
  localparam logic [7:0] KeyTab   = 8'd9;
  localparam logic [7:0] KeyLf    = 8'd10;
  localparam logic [7:0] KeyCr    = 8'd13;
  localparam logic [7:0] KeyEsc   = 8'd27;
  localparam logic [7:0] KeyCsi   = 8'd91;
  localparam logic [7:0] KeyRight = 8'd67;
  localparam logic [7:0] KeyLeft  = 8'd68;
  localparam logic [7:0] KeyDel3  = 8'd51;
  localparam logic [7:0] KeyTilde = 8'd126;
  localparam logic [7:0] KeyRub   = 8'd255;

  // echo characters
  localparam logic [7:0] ChBs    = 8'd8;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChNl    = 8'd10;
  localparam logic [7:0] ChNone  = 8'd0;

  // result kinds
  localparam logic [1:0] KindEcho = 2'd0;
  localparam logic [1:0] KindLine = 2'd1;
  localparam logic [1:0] KindEnd  = 2'd2;

  // escape decoder phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_CSI  = 3'd2,
    PH_DEL  = 3'd3
  } esc_phase_e;

  // edit sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RIGHT,
    ST_LEFT,
    ST_BKSP,
    ST_DEL_SHIFT,
    ST_INS_SHIFT,
    ST_TAIL,
    ST_SPACE,
    ST_BS,
    ST_NL,
    ST_LINE
  } cle_state_e;

endpackage

// ===== sv/console_line_editor_core.sv =====
// console line editor core
//
// Input channel: one received key byte per beat on key_i (in_valid_i /
// in_stall_o). Output channel: echo bytes, completed line bytes and a
// line-end marker on kind_o / out_byte_o / last_o (out_valid_o /
// out_stall_i); last_o marks the final beat caused by a key.
//
// A key is taken only while the sequencer is idle. It then works through
// the line one entry per cycle: shifting the line store up or down through
// its single read and write port, then sending the tail, for a delete a
// space, and backspaces one beat per cycle, while the receiver does not
// stall, through the output register. Escape bytes and ignored keys leave
// the sequencer idle. An edit shifts up to LINE_DEPTH entries and sends at
// most 2 * LINE_DEPTH + 1 result beats (63 at the default depth).
// The output register lets a new key be taken while the last result beat
// still waits; a stalled receiver holds the sequencer on its next beat.
// Reset empties the line, homes the cursor and returns the escape decoder
// to idle; the line contents are not cleared and never read before written.
module console_line_editor_core import cle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LineDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  localparam int unsigned ADDR_W = $clog2(LINE_DEPTH);
  localparam int unsigned IDX_W  = $clog2(LINE_DEPTH + 1);
  localparam logic [IDX_W-1:0] DepthIdx = IDX_W'(LINE_DEPTH);
  localparam logic [IDX_W-1:0] OneIdx   = IDX_W'(1);

  cle_state_e       state_q, state_d;
  esc_phase_e       phase_q, phase_d;
  logic [IDX_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             del_q, del_d;
  logic [7:0]       key_q, key_d;

  logic             out_valid_q;
  logic [1:0]       kind_q;
  logic [7:0]       byte_q;
  logic             last_q;

  logic             out_free;
  logic             emit_req;
  logic [1:0]       emit_kind;
  logic [7:0]       emit_byte;
  logic             emit_last;

  logic             st_we;
  logic [IDX_W-1:0] st_waddr;
  logic [7:0]       st_wdata;
  logic [IDX_W-1:0] st_raddr;
  logic [7:0]       st_rdata;

  logic [IDX_W:0]   idx_inc;
  logic             tail_last;
  logic             bs_last;

  // line store
  cle_line_store #(
    .LINE_DEPTH(LINE_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr[ADDR_W-1:0]),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr[ADDR_W-1:0]),
    .rdata_o(st_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // shared index incrementer and end tests
  assign idx_inc   = {1'b0, idx_q} + {1'b0, OneIdx};
  assign tail_last = !del_q && (idx_inc == {1'b0, len_q}) && (cur_q == len_q);
  assign bs_last   = del_q ? (idx_q == len_q) : (idx_inc == {1'b0, len_q});

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_IDLE;
      len_q   <= '0;
      cur_q   <= '0;
      idx_q   <= '0;
      del_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      idx_q   <= idx_d;
      del_q   <= del_d;
    end
  end

  // held key byte for insert
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // sequencer: next state, store access and beat request
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    len_d     = len_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    del_d     = del_q;
    key_d     = key_q;
    emit_req  = 1'b0;
    emit_kind = KindEcho;
    emit_byte = ChNone;
    emit_last = 1'b0;
    st_we     = 1'b0;
    st_waddr  = idx_q;
    st_wdata  = st_rdata;
    st_raddr  = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          phase_d = PH_IDLE;
          case (phase_q)
            PH_ESC: begin
              if (key_i == KeyCsi) begin
                phase_d = PH_CSI;
              end
            end
            PH_CSI: begin
              if (key_i == KeyRight) begin
                if (cur_q < len_q) begin
                  state_d = ST_RIGHT;
                end
              end else if (key_i == KeyLeft) begin
                if (cur_q != '0) begin
                  state_d = ST_LEFT;
                end
              end else if (key_i == KeyDel3) begin
                phase_d = PH_DEL;
              end
            end
            PH_DEL: begin
              if (key_i == KeyTilde && cur_q < len_q) begin
                state_d = ST_DEL_SHIFT;
                idx_d   = cur_q;
                del_d   = 1'b1;
              end
            end
            default: begin
              if (key_i == KeyTab) begin
                // tab is ignored
              end else if (key_i == KeyLf || key_i == KeyCr) begin
                state_d = ST_NL;
              end else if (key_i == KeyEsc) begin
                phase_d = PH_ESC;
              end else if (key_i == KeyBs || key_i == KeyRub) begin
                if (cur_q != '0) begin
                  state_d = ST_BKSP;
                  del_d   = 1'b1;
                end
              end else if (len_q < DepthIdx) begin
                state_d = ST_INS_SHIFT;
                idx_d   = len_q;
                key_d   = key_i;
                del_d   = 1'b0;
              end
            end
          endcase
        end
      end

      // cursor right: echo the byte under the cursor
      ST_RIGHT: begin
        st_raddr  = cur_q;
        emit_req  = 1'b1;
        emit_byte = st_rdata;
        emit_last = 1'b1;
        if (out_free) begin
          cur_d   = cur_q + OneIdx;
          state_d = ST_IDLE;
        end
      end

      // cursor left: one backspace
      ST_LEFT: begin
        emit_req  = 1'b1;
        emit_byte = ChBs;
        emit_last = 1'b1;
        if (out_free) begin
          cur_d   = cur_q - OneIdx;
          state_d = ST_IDLE;
        end
      end

      // backspace key: step left, then delete at the cursor
      ST_BKSP: begin
        emit_req  = 1'b1;
        emit_byte = ChBs;
        if (out_free) begin
          cur_d   = cur_q - OneIdx;
          idx_d   = cur_q - OneIdx;
          state_d = ST_DEL_SHIFT;
        end
      end

      // close the gap one entry per cycle
      ST_DEL_SHIFT: begin
        st_raddr = idx_inc[IDX_W-1:0];
        if (idx_inc < {1'b0, len_q}) begin
          st_we    = 1'b1;
          st_waddr = idx_q;
          idx_d    = idx_inc[IDX_W-1:0];
        end else begin
          len_d   = len_q - OneIdx;
          idx_d   = cur_q;
          state_d = ST_TAIL;
        end
      end

      // open a gap one entry per cycle, then drop the key in
      ST_INS_SHIFT: begin
        st_raddr = idx_q - OneIdx;
        if (idx_q > cur_q) begin
          st_we    = 1'b1;
          st_waddr = idx_q;
          idx_d    = idx_q - OneIdx;
        end else begin
          st_we    = 1'b1;
          st_waddr = cur_q;
          st_wdata = key_q;
          cur_d    = cur_q + OneIdx;
          len_d    = len_q + OneIdx;
          idx_d    = cur_q;
          state_d  = ST_TAIL;
        end
      end

      // redraw the tail of the line
      ST_TAIL: begin
        if (idx_q < len_q) begin
          emit_req  = 1'b1;
          emit_byte = st_rdata;
          emit_last = tail_last;
          if (out_free) begin
            idx_d = idx_inc[IDX_W-1:0];
            if (tail_last) begin
              state_d = ST_IDLE;
            end
          end
        end else if (del_q) begin
          state_d = ST_SPACE;
        end else begin
          idx_d   = cur_q;
          state_d = ST_BS;
        end
      end

      // blank the old last column
      ST_SPACE: begin
        emit_req  = 1'b1;
        emit_byte = ChSpace;
        if (out_free) begin
          idx_d   = cur_q;
          state_d = ST_BS;
        end
      end

      // walk the terminal cursor back
      ST_BS: begin
        emit_req  = 1'b1;
        emit_byte = ChBs;
        emit_last = bs_last;
        if (out_free) begin
          idx_d = idx_inc[IDX_W-1:0];
          if (bs_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      // line complete: newline echo
      ST_NL: begin
        emit_req  = 1'b1;
        emit_byte = ChNl;
        if (out_free) begin
          idx_d   = '0;
          state_d = ST_LINE;
        end
      end

      // line bytes, then the line-end marker
      ST_LINE: begin
        emit_req = 1'b1;
        if (idx_q < len_q) begin
          emit_kind = KindLine;
          emit_byte = st_rdata;
          if (out_free) begin
            idx_d = idx_inc[IDX_W-1:0];
          end
        end else begin
          emit_kind = KindEnd;
          emit_byte = ChNone;
          emit_last = 1'b1;
          if (out_free) begin
            len_d   = '0;
            cur_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit_req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit_req) begin
      kind_q <= emit_kind;
      byte_q <= emit_byte;
      last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

  // cursor never passes the end of the line
  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_q <= len_q)
    else $error("cursor beyond line end");

  // line never exceeds the store
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= DepthIdx)
    else $error("line longer than store");

  // the line-end marker always closes a key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KindEnd) |-> last_o)
    else $error("line-end marker without last");

endmodule

// ===== sv/cle_line_store.sv =====
module cle_line_store import cle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LineDepthDef,
  parameter int unsigned ADDR_W     = $clog2(LINE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [LINE_DEPTH];

  // single write port, no reset on line contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // single read port
  assign rdata_o = mem_q[raddr_i];

endmodule

// ===== verif/console_line_editor_checker.sv =====
`timescale 1ns / 1ps

module console_line_editor_checker import cle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LineDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] key_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam int MaxBeats = 64;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } editor_beat_t;

  // shadow copy of the editor state
  logic [7:0] line_buf [LINE_DEPTH];
  logic [4:0] line_len;
  logic [4:0] cursor;
  esc_phase_e phase;

  editor_beat_t echo_beats [$];
  int key_beats;
  int fails;
  int pending_cnt;

  assign fail_count_o = fails;
  assign pending_o    = pending_cnt;

  // queue one expected beat, capped per key
  task automatic push_beat(input logic [1:0] k, input logic [7:0] d);
    editor_beat_t b;
    if (key_beats < MaxBeats) begin
      b.kind = k;
      b.data = d;
      b.last = 1'b0;
      echo_beats.push_back(b);
      key_beats++;
    end
  endtask

  // cursor one left with a backspace echo
  task automatic step_left();
    if (cursor > 0) begin
      cursor = cursor - 1'b1;
      push_beat(KindEcho, ChBs);
    end
  endtask

  // remove the byte under the cursor and redraw the tail
  task automatic erase_at_cursor();
    int i;
    if (cursor < line_len) begin
      for (i = int'(cursor); i + 1 < int'(line_len); i++) line_buf[i] = line_buf[i + 1];
      line_len = line_len - 1'b1;
      for (i = int'(cursor); i < int'(line_len); i++) push_beat(KindEcho, line_buf[i]);
      push_beat(KindEcho, ChSpace);
      for (i = int'(cursor); i < int'(line_len) + 1; i++) push_beat(KindEcho, ChBs);
    end
  endtask

  // expected beats for one accepted key
  task automatic predict_key(input logic [7:0] k);
    editor_beat_t b;
    int i;
    key_beats = 0;
    case (phase)
      PH_ESC: begin
        phase = (k == KeyCsi) ? PH_CSI : PH_IDLE;
      end
      PH_CSI: begin
        phase = PH_IDLE;
        if (k == KeyRight) begin
          if (cursor < line_len) begin
            push_beat(KindEcho, line_buf[cursor]);
            cursor = cursor + 1'b1;
          end
        end else if (k == KeyLeft) begin
          step_left();
        end else if (k == KeyDel3) begin
          phase = PH_DEL;
        end
      end
      PH_DEL: begin
        phase = PH_IDLE;
        if (k == KeyTilde) erase_at_cursor();
      end
      default: begin
        phase = PH_IDLE;
        if (k == KeyTab) begin
          // tab does nothing
        end else if (k == KeyLf || k == KeyCr) begin
          push_beat(KindEcho, ChNl);
          for (i = 0; i < int'(line_len); i++) push_beat(KindLine, line_buf[i]);
          push_beat(KindEnd, ChNone);
          if (line_len != 0) begin
            line_len = '0;
            cursor   = '0;
          end
        end else if (k == KeyEsc) begin
          phase = PH_ESC;
        end else if (k == KeyBs || k == KeyRub) begin
          if (cursor > 0) begin
            step_left();
            erase_at_cursor();
          end
        end else if (line_len < LINE_DEPTH) begin
          // insert at the cursor, echo the tail and walk back
          for (i = int'(line_len); i > int'(cursor); i--) line_buf[i] = line_buf[i - 1];
          line_buf[cursor] = k;
          cursor   = cursor + 1'b1;
          line_len = line_len + 1'b1;
          for (i = int'(cursor) - 1; i < int'(line_len); i++) push_beat(KindEcho, line_buf[i]);
          for (i = int'(cursor); i < int'(line_len); i++) push_beat(KindEcho, ChBs);
        end
      end
    endcase
    // flag the final beat of this key
    if (key_beats > 0) begin
      b = echo_beats.pop_back();
      b.last = 1'b1;
      echo_beats.push_back(b);
    end
  endtask

  // watch both channels, predict on key beats, compare result beats
  always @(posedge clk_i or negedge rst_ni) begin
    editor_beat_t want;
    if (!rst_ni) begin
      line_len = '0;
      cursor   = '0;
      phase    = PH_IDLE;
      echo_beats.delete();
      pending_cnt = 0;
      fails       = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_key(key_i);
      if (out_valid_i && !out_stall_i) begin
        if (echo_beats.size() == 0) begin
          $error("unexpected result beat: kind %0d, out_byte 0x%02h, last %0b",
                 kind_i, out_byte_i, last_i);
          fails++;
        end else begin
          want = echo_beats.pop_front();
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind_i);
            fails++;
          end
          if (out_byte_i !== want.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, out_byte_i);
            fails++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last_i);
            fails++;
          end
        end
      end
      pending_cnt = echo_beats.size();
    end
  end

endmodule

// ===== verif/console_line_editor_core_tb.sv =====
`timescale 1ns / 1ps

module console_line_editor_core_tb;
  import cle_pkg::*;

  localparam int RandomKeys  = 380;
  localparam int DrainCycles = 200;

  // sequence bytes that the editor drops
  localparam logic [7:0] KeyPageUp = 8'd53;
  localparam logic [7:0] KeyPageDn = 8'd54;
  localparam logic [7:0] KeyUp     = 8'd65;
  localparam logic [7:0] KeyDown   = 8'd66;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] key;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last_beat;
  int         fail_count;
  int         pending;

  int keys_sent;
  bit no_idle;

  console_line_editor_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .key_i      (key),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .kind_o     (kind),
    .out_byte_o (out_byte),
    .last_o     (last_beat)
  );

  console_line_editor_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .key_i       (key),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .kind_i      (kind),
    .out_byte_i  (out_byte),
    .last_i      (last_beat),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver stalls: mostly short, a few long, some stall-free stretches
  initial begin
    int hold;
    int free_run;
    int pick;
    hold     = 0;
    free_run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (free_run > 0) begin
        free_run--;
        out_stall <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          out_stall <= 1'b0;
        end else if (pick < 92) begin
          hold = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else if (pick < 97) begin
          hold = $urandom_range(5, 40);
          out_stall <= 1'b1;
        end else begin
          free_run = $urandom_range(50, 200);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // one key beat, with an optional gap before it
  task automatic send_key(input logic [7:0] k);
    int gap;
    int pick;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (!no_idle) begin
      if (pick >= 97) gap = $urandom_range(20, 60);
      else if (pick >= 85) gap = $urandom_range(4, 10);
      else if (pick >= 50) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    key      <= k;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (k != KeyTab) keys_sent++;
  endtask

  // ESC [ and a final byte
  task automatic send_csi(input logic [7:0] fin);
    send_key(KeyEsc);
    send_key(KeyCsi);
    send_key(fin);
  endtask

  // hold the sender until every expected beat is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // stimulus and verdict
  initial begin
    int pick;
    int n;
    in_valid  = 1'b0;
    key       = '0;
    rst_n     = 1'b0;
    keys_sent = 0;
    no_idle   = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // edges of an empty line
    send_key(KeyBs);
    send_key(KeyRub);
    send_csi(KeyLeft);
    send_key(KeyCr);
    send_key(KeyTab);
    // extreme bytes inserted, cursor walks
    send_key(8'h00);
    send_key(8'hfe);
    send_key(8'h78);
    send_csi(KeyLeft);
    send_csi(KeyRight);
    send_csi(KeyRight);
    send_csi(KeyLeft);
    send_csi(KeyDel3);
    send_key(KeyTilde);
    send_csi(KeyDel3);
    send_key(KeyTilde);
    send_key(KeyRub);
    // dropped sequences
    send_csi(KeyPageUp);
    send_csi(KeyPageDn);
    send_csi(KeyUp);
    send_csi(KeyDown);
    send_key(KeyEsc);
    send_key(8'h71);
    send_key(KeyLf);
    wait_drained();

    // overfill the line, then send it
    repeat (LineDepthDef + 3) send_key(8'($urandom_range(32, 125)));
    send_key(KeyCr);

    while (keys_sent < RandomKeys) begin
      pick = $urandom_range(0, 99);
      if (pick < 44) begin
        n = $urandom_range(1, 3);
        repeat (n) send_key(8'($urandom_range(32, 125)));
      end else if (pick < 54) begin
        send_csi(KeyLeft);
      end else if (pick < 62) begin
        send_csi(KeyRight);
      end else if (pick < 69) begin
        send_key($urandom_range(0, 1) ? KeyBs : KeyRub);
      end else if (pick < 76) begin
        send_csi(KeyDel3);
        send_key(KeyTilde);
      end else if (pick < 81) begin
        send_key($urandom_range(0, 1) ? KeyCr : KeyLf);
      end else if (pick < 83) begin
        n = $urandom_range(10, LineDepthDef + 3);
        repeat (n) send_key(8'($urandom_range(32, 125)));
      end else if (pick < 89) begin
        send_key(8'($urandom));
      end else if (pick < 95) begin
        // broken sequences
        n = $urandom_range(0, 2);
        send_key(KeyEsc);
        if (n > 0) send_key(KeyCsi);
        if (n > 1) send_key(KeyDel3);
        send_key(8'($urandom));
      end else if (pick < 98) begin
        case ($urandom_range(0, 4))
          0: send_csi(KeyPageUp);
          1: send_csi(KeyPageDn);
          2: send_csi(KeyUp);
          3: send_csi(KeyDown);
          default: send_key(KeyTab);
        endcase
      end else begin
        wait_drained();
        no_idle = ~no_idle;
      end
    end

    // drain
    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
